@@ sv/vlqd_pkg.sv @@
// Shared types and constants for the VLQ mapping stream decoder.
package vlqd_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int DEF_MAX_DIGITS  = 7;
  localparam int DIGIT_BITS      = 5;
  localparam int ACC_WIDTH       = 32;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_SEMI  = 8'h3B;

  // Field positions within a segment
  localparam logic [2:0] FIELD_GEN_COL     = 3'd0;
  localparam logic [2:0] FIELD_FILE_INDEX  = 3'd1;
  localparam logic [2:0] FIELD_SOURCE_LINE = 3'd2;
  localparam logic [2:0] FIELD_SOURCE_COL  = 3'd3;
  localparam logic [2:0] FIELD_COUNT_MAX   = 3'd7;

  // Segment sizes that produce an entry
  localparam logic [2:0] SEG_COLUMN_ONLY = 3'd1;
  localparam logic [2:0] SEG_WITH_SOURCE = 3'd4;
  localparam logic [2:0] SEG_WITH_NAME   = 3'd5;

  typedef enum logic [2:0] {
    ST_ENTRY     = 3'd0,
    ST_BAD_CHAR  = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_BAD_COUNT = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    TOK_DIGIT,
    TOK_COMMA,
    TOK_SEMI,
    TOK_BAD
  } tok_kind_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [31:0] gen_line;
    logic [31:0] gen_col;
    logic [31:0] file_index;
    logic [31:0] source_line;
    logic [31:0] source_col;
    logic [2:0]  status;
  } map_item_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [5:0] digit;
    logic       last;
  } tok_t;

endpackage

@@ sv/vlqd_front.sv @@
// Front end: classify each character into a digit, separator or bad token.
module vlqd_front (
  input  logic                 char_valid,
  output logic                 char_ready,
  input  vlqd_pkg::char_item_t char_item,
  output logic                 push_valid,
  input  logic                 push_ready,
  output vlqd_pkg::tok_t       push_data
);
  import vlqd_pkg::*;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;

  logic [7:0] code;

  assign code       = char_item.char_code;
  assign push_valid = char_valid;
  assign char_ready = push_ready;

  always_comb begin
    push_data.last  = char_item.last;
    push_data.digit = 6'd0;
    push_data.kind  = TOK_DIGIT;
    if (code == CHAR_COMMA) begin
      push_data.kind = TOK_COMMA;
    end else if (code == CHAR_SEMI) begin
      push_data.kind = TOK_SEMI;
    end else if (code >= CHAR_UPPER_A && code <= CHAR_UPPER_Z) begin
      push_data.digit = 6'(code - CHAR_UPPER_A);
    end else if (code >= CHAR_LOWER_A && code <= CHAR_LOWER_Z) begin
      push_data.digit = 6'(code - CHAR_LOWER_A + 8'd26);
    end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      push_data.digit = 6'(code - CHAR_ZERO + 8'd52);
    end else if (code == CHAR_PLUS) begin
      push_data.digit = 6'd62;
    end else if (code == CHAR_SLASH) begin
      push_data.digit = 6'd63;
    end else begin
      push_data.kind = TOK_BAD;
    end
  end

endmodule

@@ sv/vlqd_queue.sv @@
// Short token queue between the classifier and the decode back end.
module vlqd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push_valid,
  output logic           push_ready,
  input  vlqd_pkg::tok_t push_data,
  output logic           pop_valid,
  input  logic           pop_ready,
  output vlqd_pkg::tok_t pop_data
);
  import vlqd_pkg::*;

  localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  tok_t           slots [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QCW-1:0] count;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count != QCW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= QCW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  assert property (@(posedge clk) disable iff (rst)
    do_push && !do_pop |=> count == $past(count) + 1'b1)
    else $error("queue count missed a push");
  assert property (@(posedge clk) disable iff (rst)
    (wr_ptr == rd_ptr) |-> (count == '0 || count == QCW'(QUEUE_DEPTH)))
    else $error("queue pointers disagree with count");

endmodule

@@ sv/vlqd_back.sv @@
// Back end: VLQ value assembly, accumulators, segment checks and result register.
module vlqd_back #(
  parameter int VALUE_WIDTH = vlqd_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = vlqd_pkg::DEF_MAX_DIGITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  vlqd_pkg::tok_t      tok,
  output logic                map_valid,
  input  logic                map_ready,
  output vlqd_pkg::map_item_t map_item
);
  import vlqd_pkg::*;

  localparam int DCW = $clog2(MAX_DIGITS + 1);
  localparam int SHW = $clog2(DIGIT_BITS * MAX_DIGITS + 1);

  logic [ACC_WIDTH-1:0]   acc_gen_col,     acc_gen_col_next;
  logic [ACC_WIDTH-1:0]   acc_file_index,  acc_file_index_next;
  logic [ACC_WIDTH-1:0]   acc_source_line, acc_source_line_next;
  logic [ACC_WIDTH-1:0]   acc_source_col,  acc_source_col_next;
  logic [ACC_WIDTH-1:0]   line_counter,    line_counter_next;
  logic [VALUE_WIDTH-1:0] value_reg,       value_reg_next;
  logic [DCW-1:0]         digit_count,     digit_count_next;
  logic [2:0]             field_count,     field_count_next;
  logic                   error_hold,      error_hold_next;

  logic                   pop;
  logic                   emit;
  status_t                code;
  map_item_t              res;
  logic [SHW-1:0]         shamt;
  logic [VALUE_WIDTH-1:0] term;
  logic [VALUE_WIDTH-1:0] vsum;
  logic [VALUE_WIDTH-1:0] mag;
  logic [ACC_WIDTH-1:0]   delta;
  logic                   seg_end;

  assign pop_ready = !map_valid || map_ready;
  assign pop       = pop_valid && pop_ready;
  assign shamt     = SHW'(digit_count) * SHW'(DIGIT_BITS);
  assign term      = VALUE_WIDTH'(tok.digit[DIGIT_BITS-1:0]) << shamt;
  assign vsum      = value_reg | term;
  assign mag       = vsum >> 1;
  assign delta     = vsum[0] ? (ACC_WIDTH'(0) - ACC_WIDTH'(mag)) : ACC_WIDTH'(mag);
  assign seg_end   = (tok.kind == TOK_COMMA) || (tok.kind == TOK_SEMI) || tok.last;

  always_comb begin
    acc_gen_col_next     = acc_gen_col;
    acc_file_index_next  = acc_file_index;
    acc_source_line_next = acc_source_line;
    acc_source_col_next  = acc_source_col;
    line_counter_next    = line_counter;
    value_reg_next       = value_reg;
    digit_count_next     = digit_count;
    field_count_next     = field_count;
    error_hold_next      = error_hold;
    code                 = ST_ENTRY;
    emit                 = 1'b0;
    res                  = '0;

    if (!error_hold) begin
      if (tok.kind == TOK_BAD) begin
        code = ST_BAD_CHAR;
      end else if (tok.kind == TOK_DIGIT) begin
        if (digit_count >= DCW'(MAX_DIGITS)) begin
          code = ST_TOO_LONG;
        end else if (tok.digit[DIGIT_BITS]) begin
          // continuation: hold partial value
          value_reg_next   = vsum;
          digit_count_next = digit_count + 1'b1;
        end else begin
          // value complete: apply delta to the field's accumulator
          value_reg_next   = '0;
          digit_count_next = '0;
          case (field_count)
            FIELD_GEN_COL:     acc_gen_col_next     = acc_gen_col + delta;
            FIELD_FILE_INDEX:  acc_file_index_next  = acc_file_index + delta;
            FIELD_SOURCE_LINE: acc_source_line_next = acc_source_line + delta;
            FIELD_SOURCE_COL:  acc_source_col_next  = acc_source_col + delta;
            default: ;
          endcase
          if (field_count != FIELD_COUNT_MAX) begin
            field_count_next = field_count + 1'b1;
          end
        end
      end

      if (code == ST_ENTRY && seg_end) begin
        if (digit_count_next != '0) begin
          code = ST_TRUNCATED;
        end else if (field_count_next == SEG_COLUMN_ONLY ||
                     field_count_next == SEG_WITH_SOURCE ||
                     field_count_next == SEG_WITH_NAME) begin
          emit            = 1'b1;
          res.gen_line    = line_counter;
          res.gen_col     = acc_gen_col_next;
          res.file_index  = acc_file_index_next;
          res.source_line = acc_source_line_next;
          res.source_col  = acc_source_col_next;
          res.status      = ST_ENTRY;
        end else if (field_count_next != '0) begin
          code = ST_BAD_COUNT;
        end
        if (code == ST_ENTRY && tok.kind == TOK_SEMI) begin
          // advance line, restart column
          line_counter_next = line_counter + 1'b1;
          acc_gen_col_next  = '0;
        end
        field_count_next = '0;
      end

      if (code != ST_ENTRY) begin
        emit            = 1'b1;
        res             = '0;
        res.status      = code;
        error_hold_next = 1'b1;
      end
    end

    if (tok.last) begin
      acc_gen_col_next     = '0;
      acc_file_index_next  = '0;
      acc_source_line_next = '0;
      acc_source_col_next  = '0;
      line_counter_next    = '0;
      value_reg_next       = '0;
      digit_count_next     = '0;
      field_count_next     = '0;
      error_hold_next      = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_gen_col     <= '0;
      acc_file_index  <= '0;
      acc_source_line <= '0;
      acc_source_col  <= '0;
      line_counter    <= '0;
      value_reg       <= '0;
      digit_count     <= '0;
      field_count     <= '0;
      error_hold      <= 1'b0;
      map_valid       <= 1'b0;
    end else begin
      if (pop) begin
        acc_gen_col     <= acc_gen_col_next;
        acc_file_index  <= acc_file_index_next;
        acc_source_line <= acc_source_line_next;
        acc_source_col  <= acc_source_col_next;
        line_counter    <= line_counter_next;
        value_reg       <= value_reg_next;
        digit_count     <= digit_count_next;
        field_count     <= field_count_next;
        error_hold      <= error_hold_next;
        map_valid       <= emit;
      end else if (map_ready) begin
        map_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      map_item <= res;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    pop && emit && res.status != ST_ENTRY && !tok.last |=> error_hold)
    else $error("error result did not set the hold");
  assert property (@(posedge clk) disable iff (rst) error_hold && pop |-> !emit)
    else $error("result produced while an error is held");
  assert property (@(posedge clk) disable iff (rst) digit_count <= DCW'(MAX_DIGITS))
    else $error("digit count beyond limit");
  assert property (@(posedge clk) disable iff (rst)
    pop && tok.last |=> line_counter == '0 && field_count == '0 && !error_hold)
    else $error("state not cleared after the last character");

endmodule

@@ sv/vlq_mapping_stream_decoder.sv @@
// Top level of the VLQ mapping stream decoder: classifier, token queue, decode back end.
//
// Usage:
//   char channel (char_valid / char_ready / char_item) takes one character of a
//   mappings string per transaction; char_item.last marks its final character.
//   map channel (map_valid / map_ready / map_item) gives zero or one result per
//   character: an entry (status 0) with the line count and accumulated columns,
//   file index and source line, or an error code with all other fields zero.
// Path: a character is classified and written into the token queue when it is
//   taken; the back end pops it from the queue and registers its result in the
//   output register, from which the receiver takes it.
// Throughput: one character per cycle while map_ready is held high. The decode back end
//   handles a base64 digit, its accumulator add and the segment checks combinationally.
// Stall: when the receiver holds map_ready low, the back end holds its result
//   and the two-entry token queue absorbs characters until full; char_ready then
//   drops until the result is taken.
// Reset: rst (synchronous) empties the queue, drops any pending result and
//   clears all accumulators, counters and the error hold. The back end clears
//   the same accumulators, counters and hold after every character marked last, ready for the next string.
// After an error result, characters are dropped without result up to the last.
module vlq_mapping_stream_decoder #(
  parameter int VALUE_WIDTH = vlqd_pkg::DEF_VALUE_WIDTH,
  parameter int MAX_DIGITS  = vlqd_pkg::DEF_MAX_DIGITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 char_valid,
  output logic                 char_ready,
  input  vlqd_pkg::char_item_t char_item,
  output logic                 map_valid,
  input  logic                 map_ready,
  output vlqd_pkg::map_item_t  map_item
);
  import vlqd_pkg::*;

  // classified tokens from front to queue
  logic push_valid;
  logic push_ready;
  tok_t push_data;

  // tokens from queue to back end
  logic pop_valid;
  logic pop_ready;
  tok_t pop_data;

  vlqd_front u_front (
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  vlqd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  vlqd_back #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .tok       (pop_data),
    .map_valid (map_valid),
    .map_ready (map_ready),
    .map_item  (map_item)
  );

endmodule
